// ===== hw/rtl/bubble_sort_early_exit_core_defines.svh =====
// Assertion macros shared by the bubble sort RTL modules.
`ifndef BUBBLE_SORT_EARLY_EXIT_CORE_DEFINES_SVH
`define BUBBLE_SORT_EARLY_EXIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define BSEE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bubble sort core: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define BSEE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bubble sort core: next-cycle check failed");

`endif

// ===== hw/rtl/bsee_pkg.sv =====
// Shared types for the bubble sort core: beats, controller states and datapath commands.
`default_nettype none

package bsee_pkg;

   // One input beat.
   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_out;
      logic               overflow;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_LOAD,
      S_PASS_RD0,
      S_CARRY,
      S_CMP_RD,
      S_CMP,
      S_PASS_END,
      S_OUT_RD,
      S_OUT_HOLD
   } state_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PASS_RD0,
      OP_CARRY,
      OP_CMP_RD,
      OP_CMP,
      OP_PASS_END,
      OP_OUT_RD,
      OP_OUT_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   // Datapath status seen by the controller.
   typedef struct packed {
      logic first_item;
      logic cmp_last;
      logic pass_stop;
      logic out_last;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bubble_sort_early_exit_core.sv =====
// Top level of the bubble sort core with early exit after a pass without swaps.
// Loading takes one beat per cycle; the beat marked last starts the sort.
// Each pass of L compares steps PASS_RD0, CARRY, L CMP_RD/CMP pairs, PASS_END; L = n-1 down to 1 or stops early.
// Each sorted result is read through the single store read port, then held while the output stalls.
// Synchronous reset clears the controller, count and overflow; the store keeps its contents.
`default_nettype none

module bubble_sort_early_exit_core
   import bsee_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer.
   bsee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Store and compare datapath.
   bsee_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/bsee_ctrl.sv =====
// Controller state machine for the bubble sort core.
`default_nettype none
`include "bubble_sort_early_exit_core_defines.svh"

module bsee_ctrl
   import bsee_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   assign req_accept = req_valid && !req_stall;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_accept && req_last) begin
               // A set of one needs no sorting.
               state_in = sts.first_item ? S_OUT_RD : S_PASS_RD0;
            end
         end
         S_PASS_RD0: state_in = S_CARRY;
         S_CARRY:    state_in = S_CMP_RD;
         S_CMP_RD:   state_in = S_CMP;
         S_CMP: begin
            state_in = sts.cmp_last ? S_PASS_END : S_CMP_RD;
         end
         S_PASS_END: begin
            state_in = sts.pass_stop ? S_OUT_RD : S_PASS_RD0;
         end
         S_OUT_RD:   state_in = S_OUT_HOLD;
         S_OUT_HOLD: begin
            if (!rsp_stall) begin
               state_in = sts.out_last ? S_LOAD : S_OUT_RD;
            end
         end
         default:    state_in = S_LOAD;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         S_LOAD: begin
            req_stall = 1'b0;
            cmd.op    = req_valid ? OP_LOAD : OP_NONE;
         end
         S_PASS_RD0: cmd.op = OP_PASS_RD0;
         S_CARRY:    cmd.op = OP_CARRY;
         S_CMP_RD:   cmd.op = OP_CMP_RD;
         S_CMP:      cmd.op = OP_CMP;
         S_PASS_END: cmd.op = OP_PASS_END;
         S_OUT_RD:   cmd.op = OP_OUT_RD;
         S_OUT_HOLD: begin
            rsp_valid = 1'b1;
            cmd.op    = rsp_stall ? OP_NONE : OP_OUT_NEXT;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   // Input and output sides are never open together.
   `BSEE_ASSERT_IMP(a_no_overlap, rsp_valid, req_stall)
   // A compare step is followed by another read or by the end of the pass.
   `BSEE_ASSERT_NXT(a_cmp_flow, state_ff == S_CMP,
                    (state_ff == S_CMP_RD) || (state_ff == S_PASS_END))
   // A delivered final beat returns the block to loading.
   `BSEE_ASSERT_NXT(a_set_done, rsp_valid && !rsp_stall && sts.out_last,
                    state_ff == S_LOAD)

endmodule

`default_nettype wire

// ===== hw/rtl/bsee_dp.sv =====
// Datapath for the bubble sort core: element store, carry register and counters.
`default_nettype none
`include "bubble_sort_early_exit_core_defines.svh"

module bsee_dp
   import bsee_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   input  wire req_type    req_data,
   output dp_sts_type      sts,
   output rsp_type         rsp_data
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   logic signed [31:0] store_mem [MAX_ELEMENTS];

   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [AW-1:0]      len_ff, len_in;
   logic               swapped_ff, swapped_in;
   logic signed [31:0] carry_ff, carry_in;
   logic signed [31:0] rd_data_ff;

   logic               full;
   logic               carry_gt;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   assign full     = (count_ff == CW'(MAX_ELEMENTS));
   assign carry_gt = (carry_ff > rd_data_ff);

   // Status toward the controller.
   assign sts.first_item = (count_ff == '0);
   assign sts.cmp_last   = ((k_ff + AW'(1)) == len_ff);
   assign sts.pass_stop  = !swapped_ff || (len_ff == AW'(1));
   assign sts.out_last   = ((CW'(k_ff) + CW'(1)) == count_ff);

   // Result payload.
   assign rsp_data.sorted_value = rd_data_ff;
   assign rsp_data.last_out     = sts.out_last;
   assign rsp_data.overflow     = ovf_ff;

   // Next values of the control registers.
   always_comb begin
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      k_in       = k_ff;
      len_in     = len_ff;
      swapped_in = swapped_ff;
      carry_in   = carry_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            k_in = '0;
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
            end
            // Compares in the first pass: one less than the stored count.
            if (req_data.last) begin
               len_in = full ? AW'(count_ff - CW'(1)) : AW'(count_ff);
            end
         end
         OP_PASS_RD0: begin
            k_in       = '0;
            swapped_in = 1'b0;
         end
         OP_CARRY: begin
            carry_in = rd_data_ff;
         end
         OP_CMP: begin
            // The larger value keeps moving up; the smaller one is written back.
            if (carry_gt) begin
               swapped_in = 1'b1;
            end else begin
               carry_in = rd_data_ff;
            end
            k_in = k_ff + AW'(1);
         end
         OP_PASS_END: begin
            len_in = len_ff - AW'(1);
            k_in   = '0;
         end
         OP_OUT_NEXT: begin
            k_in = k_ff + AW'(1);
            if (sts.out_last) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Store write and read port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = carry_ff;
      rd_en   = 1'b0;
      rd_addr = k_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            wr_en   = !full;
            wr_addr = count_ff[AW-1:0];
            wr_data = req_data.value;
         end
         OP_CMP: begin
            wr_en   = 1'b1;
            wr_data = carry_gt ? rd_data_ff : carry_ff;
         end
         OP_PASS_END: begin
            wr_en = 1'b1;
         end
         OP_PASS_RD0: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         OP_CMP_RD: begin
            rd_en   = 1'b1;
            rd_addr = k_ff + AW'(1);
         end
         OP_OUT_RD: begin
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         k_ff       <= '0;
         len_ff     <= '0;
         swapped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         k_ff       <= k_in;
         len_ff     <= len_in;
         swapped_ff <= swapped_in;
      end
   end

   // Carry register holds payload only.
   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   // Element store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Overflow can only be flagged once the store is full.
   `BSEE_ASSERT_IMP(a_ovf_full, ovf_ff, count_ff == CW'(MAX_ELEMENTS))
   // The count never runs past the capacity.
   `BSEE_ASSERT_IMP(a_count_range, cmd.op == OP_LOAD, count_ff <= CW'(MAX_ELEMENTS))

endmodule

`default_nettype wire
